@@ hdl/u8u16_pkg.sv @@
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and constants
// Byte masks for UTF-8 lead/continuation decoding and the result bundle.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [7:0] MARK_HIGH  = 8'h80;
  localparam logic [7:0] MARK_LEAD  = 8'h40;
  localparam logic [7:0] MARK_THREE = 8'h20;
  localparam logic [7:0] MASK_FOUR  = 8'h0F;
  localparam logic [7:0] MASK_SIX   = 8'h3F;
  localparam logic [7:0] MASK_FIVE  = 8'h1F;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_ONE   = 2'd1;
  localparam logic [1:0] PEND_TWO   = 2'd2;

  typedef struct packed {
    logic        emit;
    logic [15:0] code_unit;
    logic        bad_lead;
  } result_t;

endpackage

@@ hdl/u8u16_decode.sv @@
// ----------------------------------------------------------------------------
// u8u16_decode: sequence state and per-byte decode
// Holds the pending count and partial code; computes the result for one byte.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic [7:0]         byte_in,
  output u8u16_pkg::result_t res
);
  import u8u16_pkg::*;

  logic [1:0]  bytes_pending;
  logic [1:0]  bytes_pending_next;
  logic [15:0] partial_code;
  logic [15:0] partial_code_next;
  logic [15:0] merged;

  assign merged = {partial_code[9:0], byte_in[5:0] & MASK_SIX[5:0]};

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_code_next  = partial_code;
    res                = '0;
    if (bytes_pending != PEND_NONE) begin
      if (bytes_pending == PEND_ONE) begin
        res.emit          = 1'b1;
        res.code_unit     = merged;
        partial_code_next = '0;
      end else begin
        partial_code_next = merged;
      end
      bytes_pending_next = bytes_pending - 2'd1;
    end else if ((byte_in & MARK_HIGH) == '0) begin
      res.emit      = 1'b1;
      res.code_unit = {8'd0, byte_in};
    end else if ((byte_in & MARK_LEAD) == '0) begin
      res.emit     = 1'b1;
      res.bad_lead = 1'b1;
    end else if ((byte_in & MARK_THREE) != '0) begin
      partial_code_next  = {8'd0, byte_in & MASK_FOUR};
      bytes_pending_next = PEND_TWO;
    end else begin
      partial_code_next  = {8'd0, byte_in & MASK_FIVE};
      bytes_pending_next = PEND_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= PEND_NONE;
      partial_code  <= '0;
    end else if (advance) begin
      bytes_pending <= bytes_pending_next;
      partial_code  <= partial_code_next;
    end
  end

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    bytes_pending != 2'd3)
    else $error("pending count out of range");

  a_bad_lead_zero: assert property (@(posedge clk) disable iff (rst)
    res.bad_lead |-> res.emit && res.code_unit == '0)
    else $error("bad lead result carries nonzero unit");

  a_ascii_emit: assert property (@(posedge clk) disable iff (rst)
    advance && bytes_pending == PEND_NONE && !byte_in[7]
      |=> bytes_pending == PEND_NONE)
    else $error("ascii byte opened a sequence");

  a_lead_opens: assert property (@(posedge clk) disable iff (rst)
    advance && bytes_pending == PEND_NONE && byte_in[7] && byte_in[6]
      |=> bytes_pending != PEND_NONE)
    else $error("lead byte did not open a sequence");

endmodule

@@ hdl/utf8_to_utf16_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder: UTF-8 byte stream to UTF-16 BMP code units
// Input register, decode logic and a result register on stream channels.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* carries one UTF-8 byte per transfer in s_tdata.
//   Master channel m_* carries one code unit per transfer in m_tdata;
//   m_tuser is set when a continuation byte arrived where a lead byte was
//   expected (unit is then zero). A zero unit marks the end of a string.
//   Lead and middle bytes of a sequence produce no transfer; the last byte
//   produces the assembled unit.
//   An accepted byte is held in the input register and decoded there; its
//   unit is registered in the result register and offered on m_*.
//   Throughput: one byte per cycle while m_* is not stalled.
//   Reset clears both registers' valid flags and the sequence state.
//   When m_tready is low and a unit waits, the input register holds one
//   byte and s_tready drops once it is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic        m_tuser    // [0] bad_lead
);
  import u8u16_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_free;
  logic       advance;
  result_t    res;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  u8u16_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .byte_in (in_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      m_tdata <= res.code_unit;
      m_tuser <= res.bad_lead;
    end
  end

endmodule

@@ dv/utf8_to_utf16_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_test: self-checking bench for the UTF-8 decoder
// Feeds directed and random byte streams with random idle gaps on both
// channels, tracks decode state in a bench-side model and compares each
// code unit and bad-lead flag with the oldest expected unit.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_test;
  import u8u16_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [15:0] unit;
    logic        bad;
  } unit_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] byte_in
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [15:0] code_unit
  logic        m_tuser;   // [0] bad_lead

  unit_t       units_due[$];
  logic [1:0]  seq_left;
  logic [15:0] seq_bits;
  int          mismatch_count;
  int          cycle_count;
  int          stall_left;
  bit          no_idle;

  utf8_to_utf16_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // append one expected unit at the tail
  function automatic void queue_unit(unit_t u);
    units_due = {units_due, u};
  endfunction

  // advance decode state by one byte; queue the unit it completes, if any
  function automatic void decode_byte(logic [7:0] b);
    unit_t u;
    if (seq_left != PEND_NONE) begin
      seq_bits = (seq_bits << 6) | 16'(b & MASK_SIX);
      seq_left = seq_left - 2'd1;
      if (seq_left == PEND_NONE) begin
        u.unit = seq_bits;
        u.bad = 1'b0;
        queue_unit(u);
        seq_bits = '0;
      end
    end else if ((b & MARK_HIGH) == 8'h00) begin
      u.unit = {8'h00, b};
      u.bad = 1'b0;
      queue_unit(u);
    end else if ((b & MARK_LEAD) == 8'h00) begin
      u.unit = '0;
      u.bad = 1'b1;
      queue_unit(u);
    end else if ((b & MARK_THREE) != 8'h00) begin
      seq_bits = 16'(b & MASK_FOUR);
      seq_left = PEND_TWO;
    end else begin
      seq_bits = 16'(b & MASK_FIVE);
      seq_left = PEND_ONE;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // predict on accepted bytes, check on accepted units
  always @(posedge clk) begin
    unit_t want;
    if (rst) begin
      seq_left = PEND_NONE;
      seq_bits = '0;
      mismatch_count = 0;
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (units_due.size() == 0) begin
          report_mismatch("unexpected unit", m_tdata, 0);
        end else begin
          want = units_due.pop_front();
          if (m_tdata !== want.unit) report_mismatch("code_unit", m_tdata, want.unit);
          if (m_tuser !== want.bad) report_mismatch("bad_lead", m_tuser, want.bad);
        end
      end
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!no_idle && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] timeout with %0d units outstanding", $realtime, units_due.size());
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_bytes(logic [7:0] seq[]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_ascii();
    send_bytes('{8'h00, 8'h7F});
  endtask

  task automatic test_two_byte();
    send_bytes('{8'hC2, 8'hA9, 8'hDF, 8'hBF});
  endtask

  task automatic test_three_byte();
    send_bytes('{8'hE2, 8'h82, 8'hAC, 8'hEF, 8'hBF, 8'hBF});
  endtask

  task automatic test_stray_continuation();
    send_bytes('{8'h80, 8'hBF});
  endtask

  task automatic test_high_leads();
    send_bytes('{8'hF0, 8'h9F, 8'h98, 8'hFF, 8'hFF, 8'hFF});
  endtask

  // any byte inside an open sequence counts as a continuation, zero included
  task automatic test_unchecked_continuation();
    send_bytes('{8'hE1, 8'h41, 8'h00, 8'hC5, 8'hFF});
  endtask

  // mostly well-formed sequences with random payload, some raw noise
  task automatic test_random(int count, bit quiet);
    int sent;
    int kind;
    no_idle = quiet;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        send_byte({1'b0, 7'($urandom)});
        sent += 1;
      end else if (kind < 55) begin
        send_byte({3'b110, 5'($urandom)});
        send_byte({2'b10, 6'($urandom)});
        sent += 2;
      end else if (kind < 75) begin
        send_byte({4'b1110, 4'($urandom)});
        send_byte({2'b10, 6'($urandom)});
        send_byte({2'b10, 6'($urandom)});
        sent += 3;
      end else if (kind < 83) begin
        send_byte({4'b1111, 4'($urandom)});
        send_byte({2'b10, 6'($urandom)});
        send_byte({2'b10, 6'($urandom)});
        sent += 3;
      end else if (kind < 88) begin
        send_byte({2'b10, 6'($urandom)});
        sent += 1;
      end else begin
        send_byte(8'($urandom));
        sent += 1;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    no_idle = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ascii();
    test_two_byte();
    test_three_byte();
    test_stray_continuation();
    test_high_leads();
    test_unchecked_continuation();
    test_random(1200, 1'b0);
    test_random(220, 1'b1);
    test_random(220, 1'b0);

    s_tvalid <= 1'b0;
    while (units_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/u8u16_pkg.sv
hdl/u8u16_decode.sv
hdl/utf8_to_utf16_decoder.sv
dv/utf8_to_utf16_decoder_test.sv
